### rtl/zpr_pkg.sv
// types and constants of the zoom and pan pixel resampler
// used by zoom_pan_pixel_resampler_top and tb_top; no dependencies
package zpr_pkg;

	localparam int CHAN_W  = 8;
	localparam int COORD_W = 11;
	localparam int PIX_W   = 3 * CHAN_W;

	localparam logic [2:0] CFG_VIEW_X     = 3'd0;
	localparam logic [2:0] CFG_VIEW_Y     = 3'd1;
	localparam logic [2:0] CFG_ZOOM_POWER = 3'd2;
	localparam logic [2:0] CFG_SRC_WIDTH  = 3'd3;
	localparam logic [2:0] CFG_SRC_HEIGHT = 3'd4;

	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_RENDER = 1'b1;

	localparam logic [PIX_W-1:0] GREY_PIX = 24'h808080;

	typedef struct packed {
		logic               req_type;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [CHAN_W-1:0]  red;
		logic [CHAN_W-1:0]  green;
		logic [CHAN_W-1:0]  blue;
	} zpr_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
	} zpr_out_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DIV,
		S_GROW_WAIT,
		S_DONE
	} zpr_state_t;

endpackage

### rtl/zpr_ram.sv
// generic single-clock ram, one write and one read port, registered read
// no dependencies
module zpr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/zoom_pan_pixel_resampler_top.sv
// zoom and pan pixel resampler, top level
// depends on zpr_pkg and zpr_ram
//
// usage
//   in channel (in_valid/in_stall, in_data): a write word stores one source pixel,
//   a render word asks for one display pixel; a word is taken when in_valid is high
//   and in_stall low. in_stall is high whenever a render is still at work.
//   out channel (out_valid/out_stall, out_data): one word per render, none per write.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): cfg_ready is always high;
//   write only while the block is idle.
// steps per word
//   write: the pixel is stored as the word is accepted
//   magnify or plain render: accept, frame store read, result
//   shrink render: accept, scan of the clipped block (up to 4^MAX_SHRINK_LOG2 pixels),
//   drain, divide, result; the frame store read port scans the block one pixel a
//   cycle, then a bit-serial divider gives one quotient bit a cycle; grey renders go
//   from accept straight to result
// reset
//   registers return to view 0,0, zoom 0, image 256 square; the frame store is
//   not cleared and holds nothing defined until written
// stall
//   a finished result sits in the output register; the next word is accepted
//   meanwhile, and a later result waits until the register is free
module zoom_pan_pixel_resampler_top
	import zpr_pkg::*;
#(
	parameter int SRC_DIM         = 256,
	parameter int MAX_SHRINK_LOG2 = 3,
	parameter int MAX_GROW_LOG2   = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  zpr_in_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output zpr_out_t    out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW     = $clog2(SRC_DIM);
	localparam int DIM_W  = AW + 1;
	localparam int EW     = (DIM_W > 9) ? DIM_W : 9;
	localparam int SX_W   = 18;
	localparam int BW     = SX_W + MAX_SHRINK_LOG2 + 1;
	localparam int ZW     = 6;
	localparam int SK_W   = $clog2(MAX_SHRINK_LOG2 + 1);
	localparam int GZ_W   = $clog2(MAX_GROW_LOG2 + 1);
	localparam int SUM_W  = CHAN_W + 2 * MAX_SHRINK_LOG2;
	localparam int CNT_W  = 2 * MAX_SHRINK_LOG2 + 1;
	localparam int DC_W   = $clog2(SUM_W + 1);

	// configuration registers
	logic signed [15:0] view_x_q, view_y_q;
	logic signed [3:0]  zoom_q;
	logic [8:0]         src_w_q, src_h_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_x_q <= '0;
			view_y_q <= '0;
			zoom_q   <= '0;
			src_w_q  <= 9'd256;
			src_h_q  <= 9'd256;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_VIEW_X:     view_x_q <= cfg_data;
				CFG_VIEW_Y:     view_y_q <= cfg_data;
				CFG_ZOOM_POWER: zoom_q   <= cfg_data[3:0];
				CFG_SRC_WIDTH:  src_w_q  <= cfg_data[8:0];
				CFG_SRC_HEIGHT: src_h_q  <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// image size clamped to the store
	logic [EW-1:0]    sw_e, sh_e;
	logic [DIM_W-1:0] sw, sh;

	always_comb begin
		sw_e = EW'(src_w_q);
		sh_e = EW'(src_h_q);
		sw   = (sw_e > EW'(SRC_DIM)) ? DIM_W'(SRC_DIM) : DIM_W'(sw_e);
		sh   = (sh_e > EW'(SRC_DIM)) ? DIM_W'(SRC_DIM) : DIM_W'(sh_e);
	end

	// zoom saturated to its range
	logic signed [ZW-1:0] zc;
	logic                 shrink;
	logic [SK_W-1:0]      shrink_k;
	logic [GZ_W-1:0]      grow_z;

	always_comb begin
		if ($signed(zoom_q) < -MAX_SHRINK_LOG2) begin
			zc = ZW'(-MAX_SHRINK_LOG2);
		end else if ($signed(zoom_q) > MAX_GROW_LOG2) begin
			zc = ZW'(MAX_GROW_LOG2);
		end else begin
			zc = ZW'(zoom_q);
		end
		shrink   = zc[ZW-1];
		shrink_k = SK_W'(-zc);
		grow_z   = GZ_W'(zc);
	end

	// scaled-image position of the requested display pixel
	logic signed [SX_W-1:0] sx, sy, gx, gy;
	logic signed [BW-1:0]   xmin, xmax, ymin, ymax, one_k;
	logic signed [BW-1:0]   xlo, xhi, ylo, yhi;
	logic                   blk_empty, grow_in;
	logic [2*AW-1:0]        grow_addr;

	always_comb begin
		sx    = SX_W'(view_x_q) + SX_W'($signed({1'b0, in_data.col}));
		sy    = SX_W'(view_y_q) + SX_W'($signed({1'b0, in_data.row}));
		one_k = BW'(1) << shrink_k;
		xmin  = BW'(sx) <<< shrink_k;
		ymin  = BW'(sy) <<< shrink_k;
		xmax  = xmin + one_k;
		ymax  = ymin + one_k;
		xlo   = xmin[BW-1] ? '0 : xmin;
		ylo   = ymin[BW-1] ? '0 : ymin;
		xhi   = (xmax > $signed(BW'(sw))) ? $signed(BW'(sw)) : xmax;
		yhi   = (ymax > $signed(BW'(sh))) ? $signed(BW'(sh)) : ymax;
		blk_empty = (xhi <= xlo) || (yhi <= ylo);
		// floor division by a power of two
		gx      = sx >>> grow_z;
		gy      = sy >>> grow_z;
		grow_in = !gx[SX_W-1] && !gy[SX_W-1]
			&& (gx < $signed(SX_W'(sw))) && (gy < $signed(SX_W'(sh)));
		grow_addr = {gy[AW-1:0], gx[AW-1:0]};
	end

	// state machine
	zpr_state_t state_q, state_d;
	logic       in_acc, is_render, scan_en, load_out, x_last, y_last;

	logic [AW-1:0]  x_q, y_q, xs_lo_q, ys_lo_q;
	logic [AW:0]    xs_hi_q, ys_hi_q;
	logic           rd_valid_s1;
	logic [DC_W-1:0] div_cnt_q;

	assign in_acc    = in_valid && !in_stall;
	assign is_render = in_data.req_type == REQ_RENDER;
	assign x_last    = ({1'b0, x_q} + 1'b1) == xs_hi_q;
	assign y_last    = ({1'b0, y_q} + 1'b1) == ys_hi_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && is_render) begin
					if (shrink) begin
						state_d = blk_empty ? S_DONE : S_SCAN;
					end else begin
						state_d = grow_in ? S_GROW_WAIT : S_DONE;
					end
				end
			end
			S_SCAN: begin
				if (x_last && y_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN:     state_d = S_DIV;
			S_DIV: begin
				if (div_cnt_q == DC_W'(1)) begin
					state_d = S_DONE;
				end
			end
			S_GROW_WAIT: state_d = S_DONE;
			S_DONE: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall = state_q != S_IDLE;
		scan_en  = state_q == S_SCAN;
		load_out = (state_q == S_DONE) && (!out_valid || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= scan_en;
		end
	end

	// frame store
	logic              ram_we;
	logic [2*AW-1:0]   ram_waddr, ram_raddr;
	logic [PIX_W-1:0]  ram_wdata, ram_rdata;

	assign ram_we    = in_acc && !is_render && (in_data.col < SRC_DIM) && (in_data.row < SRC_DIM);
	assign ram_waddr = {AW'(in_data.row), AW'(in_data.col)};
	assign ram_wdata = {in_data.red, in_data.green, in_data.blue};
	assign ram_raddr = (state_q == S_IDLE) ? grow_addr : {y_q, x_q};

	zpr_ram #(
		.WIDTH(PIX_W),
		.DEPTH(SRC_DIM * SRC_DIM)
	) u_frame (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// accumulate and divide, one lane per channel
	logic [SUM_W-1:0] sum_q [3];
	logic [CNT_W-1:0] rem_q [3];
	logic [SUM_W-1:0] sum_n [3];
	logic [CNT_W-1:0] rem_n [3];
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W:0]   trial [3];
	logic [AW:0]      dx, dy;
	logic [PIX_W-1:0] res_q;

	assign dx = xs_hi_q - {1'b0, xs_lo_q};
	assign dy = ys_hi_q - {1'b0, ys_lo_q};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			trial[i] = {rem_q[i], sum_q[i][SUM_W-1]};
			if (trial[i] >= {1'b0, cnt_q}) begin
				rem_n[i] = CNT_W'(trial[i] - {1'b0, cnt_q});
				sum_n[i] = {sum_q[i][SUM_W-2:0], 1'b1};
			end else begin
				rem_n[i] = CNT_W'(trial[i]);
				sum_n[i] = {sum_q[i][SUM_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_acc && is_render) begin
			res_q   <= GREY_PIX;
			x_q     <= AW'(xlo);
			y_q     <= AW'(ylo);
			xs_lo_q <= AW'(xlo);
			ys_lo_q <= AW'(ylo);
			xs_hi_q <= (AW+1)'(xhi);
			ys_hi_q <= (AW+1)'(yhi);
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= '0;
				rem_q[i] <= '0;
			end
		end
		if (scan_en) begin
			cnt_q <= CNT_W'(dx * dy);
			if (x_last) begin
				x_q <= xs_lo_q;
				y_q <= y_q + 1'b1;
			end else begin
				x_q <= x_q + 1'b1;
			end
		end
		if (rd_valid_s1) begin
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= sum_q[i] + SUM_W'(ram_rdata[PIX_W-1-CHAN_W*i -: CHAN_W]);
			end
		end
		if (state_q == S_DRAIN) begin
			div_cnt_q <= DC_W'(SUM_W);
		end
		if (state_q == S_DIV) begin
			div_cnt_q <= div_cnt_q - 1'b1;
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= sum_n[i];
				rem_q[i] <= rem_n[i];
			end
			res_q <= {sum_n[0][CHAN_W-1:0], sum_n[1][CHAN_W-1:0], sum_n[2][CHAN_W-1:0]};
		end
		if (state_q == S_GROW_WAIT) begin
			res_q <= ram_rdata;
		end
	end

	// output register
	logic     out_valid_q;
	zpr_out_t out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (out_valid_q && out_stall) || load_out;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// checks
	a_rd_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> $past(state_q == S_SCAN))
		else $error("frame store read word outside block scan");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q[0] < cnt_q && rem_q[2] < cnt_q))
		else $error("divider remainder not below pixel count");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (out_valid_q && state_q == S_IDLE))
		else $error("result load did not present word and return to idle");

endmodule

### tb/tb_top.sv
// testbench for zoom_pan_pixel_resampler_top: a table of directed words, then
// random source loads and render sweeps, each render checked against a typed value or a predictor
// depends on zpr_pkg and the resampler rtl
`timescale 1ns / 100ps

module tb_top;
	import zpr_pkg::*;

	localparam int DIM = 256;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	zpr_in_t     in_data;
	logic        out_valid;
	logic        out_stall;
	zpr_out_t    out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	zoom_pan_pixel_resampler_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor copy of the frame and registers
	logic [PIX_W-1:0] frame_copy [DIM*DIM];
	bit               frame_known [DIM*DIM];
	int               pan_x, pan_y, zoom_reg, img_w, img_h;
	zpr_out_t         pixels_due [$];
	bit               failed;

	// directed table row: word, check against typed value when fixed is set
	typedef struct {
		zpr_in_t          w;
		bit               fixed;
		logic [PIX_W-1:0] want;
	} dir_row_t;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// give-up time well above the slowest correct run
	initial begin
		#50ms;
		$display("Some tests failed");
		$finish;
	end

	function automatic int floor_shift(int a, int z);
		return a >>> z;   // arithmetic shift is floor division by 2^z
	endfunction

	function automatic logic [PIX_W-1:0] render_colour(int c, int r);
		int sw, sh, z, sx, sy, scale, x0, x1, y0, y1, cnt, rs, gs, bs, xs, ys;
		logic [PIX_W-1:0] p;
		sw = (img_w > DIM) ? DIM : img_w;
		sh = (img_h > DIM) ? DIM : img_h;
		z = zoom_reg;
		if (z < -3) z = -3;
		if (z > 7) z = 7;
		sx = pan_x + c;
		sy = pan_y + r;
		if (z < 0) begin
			scale = 1 << (-z);
			x0 = sx * scale; x1 = x0 + scale;
			y0 = sy * scale; y1 = y0 + scale;
			if (x0 < 0) x0 = 0;
			if (y0 < 0) y0 = 0;
			cnt = 0; rs = 0; gs = 0; bs = 0;
			for (ys = y0; ys < y1 && ys < sh; ys++)
				for (xs = x0; xs < x1 && xs < sw; xs++) begin
					p = frame_copy[ys*DIM + xs];
					cnt++;
					rs += p[23:16]; gs += p[15:8]; bs += p[7:0];
				end
			if (cnt == 0) return GREY_PIX;
			return {8'(rs / cnt), 8'(gs / cnt), 8'(bs / cnt)};
		end
		xs = floor_shift(sx, z);
		ys = floor_shift(sy, z);
		if (xs >= 0 && xs < sw && ys >= 0 && ys < sh) return frame_copy[ys*DIM + xs];
		return GREY_PIX;
	endfunction

	// does this render touch only written pixels
	function automatic bit reads_known(int c, int r);
		int sw, sh, z, sx, sy, scale, x0, x1, y0, y1, xs, ys;
		sw = (img_w > DIM) ? DIM : img_w;
		sh = (img_h > DIM) ? DIM : img_h;
		z = zoom_reg;
		if (z < -3) z = -3;
		if (z > 7) z = 7;
		sx = pan_x + c;
		sy = pan_y + r;
		if (z < 0) begin
			scale = 1 << (-z);
			x0 = sx * scale; x1 = x0 + scale;
			y0 = sy * scale; y1 = y0 + scale;
			if (x0 < 0) x0 = 0;
			if (y0 < 0) y0 = 0;
			for (ys = y0; ys < y1 && ys < sh; ys++)
				for (xs = x0; xs < x1 && xs < sw; xs++)
					if (!frame_known[ys*DIM + xs]) return 0;
			return 1;
		end
		xs = floor_shift(sx, z);
		ys = floor_shift(sy, z);
		if (xs >= 0 && xs < sw && ys >= 0 && ys < sh) return frame_known[ys*DIM + xs];
		return 1;
	endfunction

	// sender gap logic: bursts with random pauses between
	int burst_left;

	// valid stays high between words of a burst; it drops in gaps and idle waits
	task automatic send_word(zpr_in_t w, bit fixed, logic [PIX_W-1:0] want);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data  <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// accepted at this edge: update predictor
		if (w.req_type == REQ_WRITE) begin
			if (w.col < DIM && w.row < DIM) begin
				frame_copy[w.row*DIM + w.col]  = {w.red, w.green, w.blue};
				frame_known[w.row*DIM + w.col] = 1;
			end
		end else
			pixels_due.push_back(fixed ? want : render_colour(w.col, w.row));
	endtask

	task automatic wait_idle();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (pixels_due.size() != 0) @(posedge clk);
		// a write leaves no result; let a last shrink render finish too
		while (guard < 100) begin
			@(posedge clk);
			guard++;
		end
	endtask

	task automatic set_reg(logic [2:0] idx, int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= 16'(val);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_VIEW_X:     pan_x = $signed(16'(val));
			CFG_VIEW_Y:     pan_y = $signed(16'(val));
			CFG_ZOOM_POWER: zoom_reg = $signed(4'(val));
			CFG_SRC_WIDTH:  img_w = val & 'h1ff;
			CFG_SRC_HEIGHT: img_h = val & 'h1ff;
			default: ;
		endcase
	endtask

	function automatic zpr_in_t make_word(logic t, int c, int r, logic [PIX_W-1:0] rgb);
		zpr_in_t w;
		w.req_type = t;
		w.col = COORD_W'(c);
		w.row = COORD_W'(r);
		{w.red, w.green, w.blue} = rgb;
		return w;
	endfunction

	// render a display pixel, rerolling coordinates until the read is defined
	task automatic random_render(int cmax, int rmax);
		int c, r, tries;
		tries = 0;
		do begin
			c = $urandom_range(0, cmax);
			r = $urandom_range(0, rmax);
			tries++;
		end while (!reads_known(c, r) && tries < 50);
		if (!reads_known(c, r)) begin
			c = 2047; r = 2047;  // far off image with non-negative pan
			if (!reads_known(c, r)) return;
		end
		send_word(make_word(REQ_RENDER, c, r, PIX_W'($urandom)), 0, '0);
	endtask

	// receiver: stall pattern of its own, checks every accepted word
	int stall_phase;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall   <= 1'b0;
			stall_phase <= 0;
		end else begin
			stall_phase <= stall_phase + 1;
			// quiet stretches, then runs of random stalling
			out_stall <= (stall_phase[9:8] == 2'd0) ? 1'b0 : ($urandom_range(0, 2) == 0);
		end
	end

	always @(posedge clk) begin
		zpr_out_t exp_pix;
		if (arst_n && out_valid && !out_stall) begin
			if (pixels_due.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h", $time, out_data);
				failed = 1;
			end else begin
				exp_pix = pixels_due.pop_front();
				if (out_data.out_red !== exp_pix.out_red) begin
					$display("%0t: out_red expected %h actual %h",
						$time, exp_pix.out_red, out_data.out_red);
					failed = 1;
				end
				if (out_data.out_green !== exp_pix.out_green) begin
					$display("%0t: out_green expected %h actual %h",
						$time, exp_pix.out_green, out_data.out_green);
					failed = 1;
				end
				if (out_data.out_blue !== exp_pix.out_blue) begin
					$display("%0t: out_blue expected %h actual %h",
						$time, exp_pix.out_blue, out_data.out_blue);
					failed = 1;
				end
			end
		end
	end

	dir_row_t dir_rows [$];

	initial begin
		int i, n, k, x, y, ph;
		in_valid   = 1'b0;
		in_data    = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		failed     = 0;
		burst_left = 0;
		pan_x = 0; pan_y = 0; zoom_reg = 0; img_w = 256; img_h = 256;
		for (i = 0; i < DIM*DIM; i++) frame_known[i] = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: corners, extreme colours, ignored writes, off-image greys
		dir_rows.push_back('{make_word(REQ_WRITE, 0, 0, 24'hffffff), 0, '0});
		dir_rows.push_back('{make_word(REQ_WRITE, 255, 255, 24'h000000), 0, '0});
		dir_rows.push_back('{make_word(REQ_WRITE, 1, 0, 24'h010203), 0, '0});
		dir_rows.push_back('{make_word(REQ_WRITE, 0, 1, 24'hff00aa), 0, '0});
		dir_rows.push_back('{make_word(REQ_WRITE, 1, 1, 24'h55aa55), 0, '0});
		// write outside the store is dropped
		dir_rows.push_back('{make_word(REQ_WRITE, 2047, 2047, 24'h123456), 0, '0});
		dir_rows.push_back('{make_word(REQ_WRITE, 256, 0, 24'h654321), 0, '0});
		dir_rows.push_back('{make_word(REQ_RENDER, 0, 0, 24'h000000), 1, 24'hffffff});
		dir_rows.push_back('{make_word(REQ_RENDER, 255, 255, 24'hffffff), 1, 24'h000000});
		dir_rows.push_back('{make_word(REQ_RENDER, 1, 0, 24'h0), 1, 24'h010203});
		dir_rows.push_back('{make_word(REQ_RENDER, 256, 0, 24'h0), 1, GREY_PIX});
		dir_rows.push_back('{make_word(REQ_RENDER, 0, 2047, 24'h0), 1, GREY_PIX});
		dir_rows.push_back('{make_word(REQ_RENDER, 2047, 2047, 24'h0), 1, GREY_PIX});
		foreach (dir_rows[j]) send_word(dir_rows[j].w, dir_rows[j].fixed, dir_rows[j].want);
		wait_idle();

		// shrink at the most extreme zoom (saturates), block clipped at negative pan
		set_reg(CFG_ZOOM_POWER, -8);
		set_reg(CFG_VIEW_X, -1);
		set_reg(CFG_VIEW_Y, 0);
		set_reg(CFG_SRC_WIDTH, 2);
		set_reg(CFG_SRC_HEIGHT, 2);
		send_word(make_word(REQ_RENDER, 0, 0, 24'h0), 1, GREY_PIX);
		send_word(make_word(REQ_RENDER, 1, 0, 24'h0), 0, '0);
		wait_idle();
		// zero-sized image gives grey everywhere
		set_reg(CFG_SRC_WIDTH, 0);
		set_reg(CFG_VIEW_X, 0);
		send_word(make_word(REQ_RENDER, 0, 0, 24'h0), 1, GREY_PIX);
		wait_idle();
		// magnify at top zoom with saturated size and pan extremes
		set_reg(CFG_SRC_WIDTH, 511);
		set_reg(CFG_SRC_HEIGHT, 300);
		set_reg(CFG_ZOOM_POWER, 7);
		set_reg(CFG_VIEW_X, -32768);
		set_reg(CFG_VIEW_Y, 32767);
		set_reg(3'd7, 16'hffff);  // unused index does nothing
		send_word(make_word(REQ_RENDER, 2047, 0, 24'h0), 0, '0);
		wait_idle();

		// load the top-left 16 by 16 corner; renders that would read beyond it are
		// rerolled, then random phases
		set_reg(CFG_VIEW_X, 0);
		set_reg(CFG_VIEW_Y, 0);
		set_reg(CFG_ZOOM_POWER, 0);
		for (y = 0; y < 16; y++)
			for (x = 0; x < 16; x++)
				send_word(make_word(REQ_WRITE, x, y, PIX_W'($urandom)), 0, '0);
		for (ph = 0; ph < 12; ph++) begin
			wait_idle();
			k = $urandom_range(0, 3);
			set_reg(CFG_ZOOM_POWER, (ph == 0) ? -3 : (ph == 1) ? 7 : $urandom_range(0, 15));
			set_reg(CFG_VIEW_X, (k == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40) - 20);
			set_reg(CFG_VIEW_Y, (k == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40) - 20);
			set_reg(CFG_SRC_WIDTH, (ph == 2) ? 1 : $urandom_range(1, 20));
			set_reg(CFG_SRC_HEIGHT, (ph == 3) ? 256 : $urandom_range(1, 20));
			n = 70;
			for (i = 0; i < n; i++) begin
				k = $urandom_range(0, 9);
				if (k < 2)
					// rewrite inside the loaded area, or junk outside the store
					send_word(make_word(REQ_WRITE,
						(k == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2047),
						(k == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2047),
						PIX_W'($urandom)), 0, '0);
				else if (k < 9)
					random_render(24, 24);
				else
					random_render(2047, 2047);
				// hold off until all results are home, once per phase
				if (i == n / 2) begin
					in_valid <= 1'b0;
					while (pixels_due.size() != 0) @(posedge clk);
				end
			end
		end
		wait_idle();
		if (!failed)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
